// ===== src/pmq_pkg.sv =====
// Shared types and status codes for the min priority queue.
`default_nettype none
package pmq_pkg;

    localparam int STATUS_BITS = 3;
    localparam int FIELD_BITS  = 32;
    localparam int WIDE_BITS   = 64;

    typedef logic [STATUS_BITS-1:0] status_t;

    localparam status_t ST_INSERTED  = 3'd0;
    localparam status_t ST_DUPLICATE = 3'd1;
    localparam status_t ST_FULL      = 3'd2;
    localparam status_t ST_REMOVED   = 3'd3;
    localparam status_t ST_EMPTY     = 3'd4;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic update;   // cells load their next contents this cycle
        logic mode;     // MODE_INSERT or MODE_DELETE
        logic hold;     // insert dropped (duplicate or full): no cell moves
    } ctl_t;

endpackage
`default_nettype wire

// ===== src/pmq_cell.sv =====
// One cell of the sorted array: a valid flag plus one key/value pair.
`default_nettype none
module pmq_cell #(
    parameter int KEY_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pmq_pkg::ctl_t                 ctl,
    input  wire logic [KEY_BITS-1:0]           new_key,
    input  wire logic [pmq_pkg::FIELD_BITS-1:0] new_value,
    // left neighbor (smaller keys)
    input  wire logic                          left_valid,
    input  wire logic                          left_gt,
    input  wire logic [KEY_BITS-1:0]           left_key,
    input  wire logic [pmq_pkg::FIELD_BITS-1:0] left_value,
    // right neighbor (larger keys)
    input  wire logic                          right_valid,
    input  wire logic [KEY_BITS-1:0]           right_key,
    input  wire logic [pmq_pkg::FIELD_BITS-1:0] right_value,
    output logic                               valid,
    output logic                               gt,
    output logic                               eq,
    output logic [KEY_BITS-1:0]                key,
    output logic [pmq_pkg::FIELD_BITS-1:0]     value
);
    import pmq_pkg::*;

    logic                  valid_reg, valid_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [FIELD_BITS-1:0] value_reg, value_next;
    logic                  take;

    assign gt = valid_reg && (key_reg > new_key);
    assign eq = valid_reg && (key_reg == new_key);

    // Cell opens up for insert if it holds a larger key or is the first empty one.
    assign take = gt || (!valid_reg && left_valid);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (ctl.update)
        begin
            if (ctl.mode == MODE_DELETE)
            begin
                valid_next = right_valid;
                key_next   = right_key;
                value_next = right_value;
            end
            else if (!ctl.hold && take)
            begin
                valid_next = 1'b1;
                key_next   = left_gt ? left_key : new_key;
                value_next = left_gt ? left_value : new_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign value = value_reg;

endmodule
`default_nettype wire

// ===== src/min_priority_queue.sv =====
// Top level: request sequencer and the chain of sorted cells.
// Result: a request taken at an edge has its result on the ports, with done
// high, for the single cycle that starts at the next edge.
// No request is taken while busy; busy is high for the one cycle in which
// every cell compares against the request key; cells that move shift one place.
// Reset: the queue comes up empty; only the cell valid flags and control clear.
`default_nettype none
module min_priority_queue #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           mode,
    input  wire logic [pmq_pkg::FIELD_BITS-1:0] key_in,
    input  wire logic [pmq_pkg::FIELD_BITS-1:0] value_in,
    output logic                                done,
    output logic [pmq_pkg::FIELD_BITS-1:0]      key_out,
    output logic [pmq_pkg::FIELD_BITS-1:0]      value_out,
    output pmq_pkg::status_t                    status
);
    import pmq_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  op_mode_reg;
    logic [KEY_BITS-1:0]   op_key_reg;
    logic [FIELD_BITS-1:0] op_value_reg;
    logic [FIELD_BITS-1:0] key_out_reg, key_out_next;
    logic [FIELD_BITS-1:0] value_out_reg, value_out_next;
    status_t               status_reg, status_next;

    logic                  accept;
    logic [WIDE_BITS-1:0]  key_in_wide;
    logic [WIDE_BITS-1:0]  head_key_wide;
    logic                  dup;
    logic                  full;
    ctl_t                  ctl;

    logic [CAPACITY-1:0]   cell_valid;
    logic [CAPACITY-1:0]   cell_gt;
    logic [CAPACITY-1:0]   cell_eq;
    logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
    logic [FIELD_BITS-1:0] cell_value [CAPACITY];

    assign accept      = start && !busy_reg;
    assign key_in_wide = WIDE_BITS'(key_in);

    assign dup  = |cell_eq;
    assign full = cell_valid[CAPACITY-1];

    assign ctl.update = busy_reg;
    assign ctl.mode   = op_mode_reg;
    assign ctl.hold   = dup || full;

    assign head_key_wide = WIDE_BITS'(cell_key[0]);

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                  l_valid, l_gt, r_valid;
            logic [KEY_BITS-1:0]   l_key, r_key;
            logic [FIELD_BITS-1:0] l_value, r_value;

            if (i == 0)
            begin : g_head
                assign l_valid = 1'b1;
                assign l_gt    = 1'b0;
                assign l_key   = op_key_reg;
                assign l_value = op_value_reg;
            end
            else
            begin : g_mid
                assign l_valid = cell_valid[i-1];
                assign l_gt    = cell_gt[i-1];
                assign l_key   = cell_key[i-1];
                assign l_value = cell_value[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign r_valid = 1'b0;
                assign r_key   = cell_key[i];
                assign r_value = cell_value[i];
            end
            else
            begin : g_inner
                assign r_valid = cell_valid[i+1];
                assign r_key   = cell_key[i+1];
                assign r_value = cell_value[i+1];
            end

            pmq_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .new_key     (op_key_reg),
                .new_value   (op_value_reg),
                .left_valid  (l_valid),
                .left_gt     (l_gt),
                .left_key    (l_key),
                .left_value  (l_value),
                .right_valid (r_valid),
                .right_key   (r_key),
                .right_value (r_value),
                .valid       (cell_valid[i]),
                .gt          (cell_gt[i]),
                .eq          (cell_eq[i]),
                .key         (cell_key[i]),
                .value       (cell_value[i])
            );
        end
    endgenerate

    always_comb
    begin
        busy_next      = busy_reg;
        done_next      = 1'b0;
        key_out_next   = key_out_reg;
        value_out_next = value_out_reg;
        status_next    = status_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            busy_next      = 1'b0;
            done_next      = 1'b1;
            key_out_next   = '0;
            value_out_next = '0;
            if (op_mode_reg == MODE_DELETE)
            begin
                if (cell_valid[0])
                begin
                    status_next    = ST_REMOVED;
                    key_out_next   = head_key_wide[FIELD_BITS-1:0];
                    value_out_next = cell_value[0];
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
            end
            else if (dup)
            begin
                status_next = ST_DUPLICATE;
            end
            else if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_INSERTED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_mode_reg  <= mode;
            op_key_reg   <= key_in_wide[KEY_BITS-1:0];
            op_value_reg <= value_in;
        end
        key_out_reg   <= key_out_next;
        value_out_reg <= value_out_next;
        status_reg    <= status_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign key_out   = key_out_reg;
    assign value_out = value_out_reg;
    assign status    = status_reg;

endmodule
`default_nettype wire

// ===== src/pmq_checker.sv =====
// Port-level checks for the min priority queue, bound to the top level.
`default_nettype none
module pmq_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic                           busy,
    input  wire logic                           done,
    input  wire logic [pmq_pkg::FIELD_BITS-1:0] key_out,
    input  wire logic [pmq_pkg::FIELD_BITS-1:0] value_out,
    input  wire pmq_pkg::status_t               status
);
    import pmq_pkg::*;

    // a taken request keeps the block busy for the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but busy not raised");

    // busy lasts one cycle and ends with a result
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("busy cycle not followed by a result");

    // no result without a request in flight just before
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_INSERTED || status == ST_DUPLICATE ||
                  status == ST_FULL || status == ST_REMOVED || status == ST_EMPTY))
        else $error("status code out of range");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_REMOVED) |-> (key_out == '0 && value_out == '0))
        else $error("payload not zero on a non-remove result");

endmodule

bind min_priority_queue pmq_checker u_pmq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .key_out   (key_out),
    .value_out (value_out),
    .status    (status)
);
`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for min_priority_queue: directed and random requests checked against a sorted-array model.
`timescale 1ns / 1ps
module tb;
    import pmq_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int KEY_BITS     = 32;
    localparam int RANDOM_ITEMS = 1550;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 6;
    localparam logic [FIELD_BITS-1:0] KEY_MASK =
        (KEY_BITS >= FIELD_BITS) ? '1 : ((FIELD_BITS'(1) << KEY_BITS) - 1);

    typedef struct {
        logic                  mode;
        logic [FIELD_BITS-1:0] key;
        logic [FIELD_BITS-1:0] value;
        int                    gap;
    } request_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] key;
        logic [FIELD_BITS-1:0] value;
        status_t               status;
    } reply_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  start    = 1'b0;
    logic                  mode     = MODE_INSERT;
    logic [FIELD_BITS-1:0] key_in   = '0;
    logic [FIELD_BITS-1:0] value_in = '0;
    logic                  busy;
    logic                  done;
    logic [FIELD_BITS-1:0] key_out;
    logic [FIELD_BITS-1:0] value_out;
    status_t               status;

    min_priority_queue #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .mode     (mode),
        .key_in   (key_in),
        .value_in (value_in),
        .done     (done),
        .key_out  (key_out),
        .value_out(value_out),
        .status   (status)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // sorted shadow of the queue contents
    logic [FIELD_BITS-1:0] shadow_keys[CAPACITY];
    logic [FIELD_BITS-1:0] shadow_values[CAPACITY];
    int                    shadow_count = 0;

    request_t request_backlog[$];
    reply_t   awaited_replies[$];
    int       total_requests = 0;
    int       taken_count    = 0;
    int       mismatch_count = 0;
    int       cycle_count    = 0;

    request_t staged_req;
    bit       staged    = 1'b0;
    int       gap_left  = 0;
    bit       took_request;

    task automatic report_mismatch(input string what, input logic [FIELD_BITS-1:0] got,
                                   input logic [FIELD_BITS-1:0] want);
        $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // applies one request to the shadow queue and records the reply it must give
    task automatic apply_queue_op(input logic op, input logic [FIELD_BITS-1:0] k,
                                  input logic [FIELD_BITS-1:0] v);
        reply_t                r;
        int                    pos;
        logic [FIELD_BITS-1:0] key;
        r.key    = '0;
        r.value  = '0;
        r.status = ST_INSERTED;
        key      = k & KEY_MASK;
        if (op == MODE_INSERT)
        begin
            pos = 0;
            while (pos < shadow_count && shadow_keys[pos] < key)
                pos++;
            if (pos < shadow_count && shadow_keys[pos] == key)
                r.status = ST_DUPLICATE;
            else if (shadow_count >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                for (int i = shadow_count; i > pos; i--)
                begin
                    shadow_keys[i]   = shadow_keys[i-1];
                    shadow_values[i] = shadow_values[i-1];
                end
                shadow_keys[pos]   = key;
                shadow_values[pos] = v;
                shadow_count++;
            end
        end
        else if (shadow_count == 0)
            r.status = ST_EMPTY;
        else
        begin
            r.key    = shadow_keys[0];
            r.value  = shadow_values[0];
            r.status = ST_REMOVED;
            for (int i = 1; i < shadow_count; i++)
            begin
                shadow_keys[i-1]   = shadow_keys[i];
                shadow_values[i-1] = shadow_values[i];
            end
            shadow_count--;
        end
        awaited_replies.push_back(r);
    endtask

    task automatic add_request(input logic op, input logic [FIELD_BITS-1:0] k,
                               input logic [FIELD_BITS-1:0] v, input int gap);
        request_t r;
        r.mode  = op;
        r.key   = k;
        r.value = v;
        r.gap   = gap;
        request_backlog.push_back(r);
    endtask

    function automatic int draw_gap(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [FIELD_BITS-1:0] draw_key(input int style);
        case (style)
            0: return $urandom_range(0, 31);
            1: return ($urandom_range(0, 1) == 0) ? FIELD_BITS'($urandom_range(0, 3))
                                                  : ~FIELD_BITS'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    // driver: request held until start && !busy at an edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            mode     <= MODE_INSERT;
            key_in   <= '0;
            value_in <= '0;
        end
        else
        begin
            took_request = start && !busy;
            if (took_request)
            begin
                apply_queue_op(mode, key_in, value_in);
                taken_count++;
            end
            if (!start || took_request)
            begin
                if (!staged && request_backlog.size() != 0)
                begin
                    staged_req = request_backlog.pop_front();
                    staged     = 1'b1;
                    gap_left   = staged_req.gap;
                end
                if (staged && gap_left == 0)
                begin
                    start    <= 1'b1;
                    mode     <= staged_req.mode;
                    key_in   <= staged_req.key;
                    value_in <= staged_req.value;
                    staged    = 1'b0;
                end
                else
                begin
                    start <= 1'b0;
                    if (staged)
                        gap_left--;
                end
            end
        end
    end

    // monitor: done marks a one-cycle reply
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (awaited_replies.size() == 0)
                report_mismatch("reply with no request waiting", FIELD_BITS'(status), '0);
            else
            begin
                reply_t want;
                want = awaited_replies.pop_front();
                if (key_out !== want.key)
                    report_mismatch("key_out", key_out, want.key);
                if (value_out !== want.value)
                    report_mismatch("value_out", value_out, want.value);
                if (status !== want.status)
                    report_mismatch("status", FIELD_BITS'(status), FIELD_BITS'(want.status));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        logic [FIELD_BITS-1:0] fill_keys[$];
        logic [FIELD_BITS-1:0] k;
        int                    random_items;
        int                    kind;
        int                    n;
        int                    insert_pct;
        int                    style;
        bit                    calm;

        // directed: empty deletes, extreme keys and values, duplicates, ordering
        add_request(MODE_DELETE, '0, '0, 0);
        add_request(MODE_INSERT, '0, '1, 0);
        add_request(MODE_INSERT, '1, '0, 3);
        add_request(MODE_INSERT, '0, 32'h0000_1234, 0);
        add_request(MODE_INSERT, '1, 32'hFFFF_0000, 1);
        add_request(MODE_INSERT, 32'h8000_0000, 32'hAAAA_AAAA, 0);
        add_request(MODE_INSERT, 32'h7FFF_FFFF, 32'h5555_5555, 0);
        add_request(MODE_DELETE, '1, '1, 0);
        add_request(MODE_DELETE, '0, '0, 5);
        add_request(MODE_INSERT, 32'h0000_0001, '0, 0);
        add_request(MODE_DELETE, $urandom, $urandom, 0);
        add_request(MODE_DELETE, $urandom, $urandom, 2);
        add_request(MODE_DELETE, $urandom, $urandom, 0);
        add_request(MODE_DELETE, '0, '0, 0);
        add_request(MODE_DELETE, '1, '1, 16);
        add_request(MODE_INSERT, '0, '0, 0);
        add_request(MODE_DELETE, '0, '0, 0);

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 4);
            calm = ($urandom_range(0, 2) == 0);
            if (kind == 0)
            begin
                // drain to empty, fill to capacity, overflow and duplicates while full, then deletes
                for (int i = 0; i < CAPACITY + 6; i++)
                    add_request(MODE_DELETE, $urandom, $urandom, draw_gap(calm));
                fill_keys.delete();
                for (int i = 0; i < CAPACITY; i++)
                begin
                    k = $urandom;
                    fill_keys.push_back(k);
                    add_request(MODE_INSERT, k, $urandom, draw_gap(calm));
                end
                for (int i = 0; i < 6; i++)
                    add_request(MODE_INSERT, $urandom, $urandom, draw_gap(calm));
                for (int i = 0; i < 4; i++)
                    add_request(MODE_INSERT, fill_keys[$urandom_range(0, CAPACITY-1)],
                                $urandom, draw_gap(calm));
                n = $urandom_range(0, CAPACITY);
                for (int i = 0; i < n; i++)
                    add_request(MODE_DELETE, $urandom, $urandom, draw_gap(calm));
                random_items += 2 * CAPACITY + 16 + n;
            end
            else
            begin
                n = $urandom_range(10, 60);
                case (kind)
                    1: insert_pct = 80;
                    2: insert_pct = 20;
                    default: insert_pct = 50;
                endcase
                for (int i = 0; i < n; i++)
                begin
                    style = (kind == 4) ? $urandom_range(0, 1) : $urandom_range(0, 2);
                    if ($urandom_range(1, 100) <= insert_pct)
                        add_request(MODE_INSERT, draw_key(style), $urandom, draw_gap(calm));
                    else
                        add_request(MODE_DELETE, $urandom, $urandom, draw_gap(calm));
                end
                random_items += n;
            end
        end
        total_requests = request_backlog.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (!(taken_count == total_requests && awaited_replies.size() == 0))
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_replies.size() != 0)
            report_mismatch("replies never returned", FIELD_BITS'(awaited_replies.size()), '0);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
